// ===== rtl/ppe_pkg.sv =====
// Package for the palette pixel expander: palette geometry, request and
// depth-mode codes, config register map and small helper functions.
// No dependencies.
package ppe_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int ENTRY_W       = 15;
  localparam int COLOR_W       = 8;
  localparam int PIXEL_W       = 16;
  localparam int CFG_AW        = 2;
  localparam int CFG_DW        = 32;

  localparam logic REQ_PALETTE_WRITE = 1'b0;
  localparam logic REQ_PIXEL_BYTE    = 1'b1;

  localparam logic [CFG_AW-1:0] REG_DEPTH_MODE_ADDR = CFG_AW'(0);

  typedef enum logic [1:0] {
    MODE_1BPP = 2'd0,
    MODE_2BPP = 2'd1,
    MODE_4BPP = 2'd2,
    MODE_8BPP = 2'd3
  } depth_mode_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               last;
  } out_word_t;

  // step number of the final pixel of a byte
  function automatic logic [2:0] last_step(depth_mode_t mode);
    logic [2:0] s;
    case (mode)
      MODE_1BPP: s = 3'd7;
      MODE_2BPP: s = 3'd3;
      MODE_4BPP: s = 3'd1;
      default:   s = 3'd0;
    endcase
    return s;
  endfunction

  // palette entry {r5, g5, b5} to display pixel, bit 5 zero
  function automatic logic [PIXEL_W-1:0] entry_to_pixel(logic [ENTRY_W-1:0] e);
    return {e[14:10], e[9:5], 1'b0, e[4:0]};
  endfunction

endpackage

// ===== rtl/palette_pixel_expander.sv =====
// Palette pixel expander top level: splits packed index bytes into pixels,
// looks each up in the palette RAM and queues RGB565-style words.
// Depends on ppe_pkg and ppe_ram.
//
//  channel | signals                                   | word
//  --------+-------------------------------------------+----------------------------
//  in      | in_valid / in_stall                       | req_type, palette_index,
//          |                                           | red, green, blue, packed_byte
//  out     | out_valid / out_stall                     | pixel, last_pixel
//  cfg     | psel penable pwrite paddr pwdata prdata   | pixel_depth_mode @ 0x0
//
// A palette write goes to the RAM when accepted; a pixel byte gives 8/4/2/1 pixels
// in 1/2/4/8-bit mode, one palette RAM read per pixel while the output queue has
// room; the next word is taken in the cycle of the last read. RAM reads are registered.
// Reset (rst, synchronous) empties the sequencer and output queue and sets
// 8-bit mode; palette contents are undefined until written.
// A stalled output holds; the two-entry output queue keeps reads flowing.
module palette_pixel_expander (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           req_type,
  input  logic [ppe_pkg::COLOR_W-1:0]    palette_index,
  input  logic [ppe_pkg::COLOR_W-1:0]    red,
  input  logic [ppe_pkg::COLOR_W-1:0]    green,
  input  logic [ppe_pkg::COLOR_W-1:0]    blue,
  input  logic [ppe_pkg::COLOR_W-1:0]    packed_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ppe_pkg::PIXEL_W-1:0]    pixel,
  output logic                           last_pixel,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ppe_pkg::CFG_AW-1:0]     paddr,
  input  logic [ppe_pkg::CFG_DW-1:0]     pwdata,
  output logic [ppe_pkg::CFG_DW-1:0]     prdata,
  output logic                           pready
);
  import ppe_pkg::*;

  depth_mode_t depth_mode;
  logic        cfg_write;

  logic        busy;
  depth_mode_t seq_mode;
  logic [7:0]  seq_byte;
  logic [2:0]  seq_step;

  logic        inflight;
  logic        inflight_last;
  logic        inflight_oob;

  out_word_t   queue [2];
  logic        head;
  logic        tail;
  logic [1:0]  count;

  logic        in_accept;
  logic        pix_accept;
  logic        pal_write;
  logic        pop;
  logic        issue;
  logic        issue_last;
  logic [7:0]  rd_index;
  logic [7:0]  seq_byte_next;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  out_word_t   push_word;

  // config port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_DEPTH_MODE_ADDR);

  always_comb begin
    prdata = '0;
    if (paddr == REG_DEPTH_MODE_ADDR) begin
      prdata = CFG_DW'(depth_mode);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode <= MODE_8BPP;
    end else if (cfg_write) begin
      depth_mode <= depth_mode_t'(pwdata[1:0]);
    end
  end

  // input side
  assign pop        = out_valid && !out_stall;
  assign issue      = busy && ({1'b0, count} + {2'b0, inflight} < 3'd2 + {2'b0, pop});
  assign issue_last = issue && (seq_step == last_step(seq_mode));
  assign in_stall   = busy && !issue_last;
  assign in_accept  = in_valid && !in_stall;
  assign pix_accept = in_accept && (req_type == REQ_PIXEL_BYTE);
  assign pal_write  = in_accept && (req_type == REQ_PALETTE_WRITE)
                      && ({1'b0, palette_index} < 9'(PALETTE_DEPTH));
  assign ram_wdata  = {red[7:3], green[7:3], blue[7:3]};

  always_comb begin
    case (seq_mode)
      MODE_1BPP: begin
        rd_index      = {7'b0, seq_byte[0]};
        seq_byte_next = seq_byte >> 1;
      end
      MODE_2BPP: begin
        rd_index      = {6'b0, seq_byte[7:6]};
        seq_byte_next = seq_byte << 2;
      end
      MODE_4BPP: begin
        rd_index      = {4'b0, seq_byte[7:4]};
        seq_byte_next = seq_byte << 4;
      end
      default: begin
        rd_index      = seq_byte;
        seq_byte_next = seq_byte;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pix_accept) begin
      busy <= 1'b1;
    end else if (issue_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      seq_mode <= depth_mode;
      seq_byte <= packed_byte;
      seq_step <= 3'd0;
    end else if (issue) begin
      seq_byte <= seq_byte_next;
      seq_step <= seq_step + 3'd1;
    end
  end

  ppe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_write),
    .waddr (palette_index[PAL_AW-1:0]),
    .wdata (ram_wdata),
    .raddr (rd_index[PAL_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 1'b0;
    end else begin
      inflight <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      inflight_last <= issue_last;
      inflight_oob  <= ({1'b0, rd_index} >= 9'(PALETTE_DEPTH));
    end
  end

  // output queue
  assign push_word.pixel = inflight_oob ? '0 : entry_to_pixel(ram_rdata);
  assign push_word.last  = inflight_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (inflight) begin
        tail <= ~tail;
      end
      if (pop) begin
        head <= ~head;
      end
      count <= count + {1'b0, inflight} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (inflight) begin
      queue[tail] <= push_word;
    end
  end

  assign out_valid  = (count != 2'd0);
  assign pixel      = queue[head].pixel;
  assign last_pixel = queue[head].last;

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, count} + {2'b0, inflight}) <= 3'd2)
    else $error("output queue over-committed");

  a_last_follows: assert property (@(posedge clk) disable iff (rst)
    issue_last |=> inflight && inflight_last)
    else $error("last read not tagged in flight");

  a_accept_when_free: assert property (@(posedge clk) disable iff (rst)
    pix_accept |-> (!busy || issue_last))
    else $error("byte accepted while sequencer holds another");

  a_idle_no_issue: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !inflight)
    else $error("read issued with no byte in progress");

endmodule

// ===== rtl/ppe_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// Read during write to the same address returns the old data. No dependencies.
module ppe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== dv/ppe_pixel_checker.sv =====
// Checker for the palette pixel expander: tracks palette writes and the depth
// mode, predicts the pixel words of each packed byte and compares them in order.
// Depends on ppe_pkg.
module ppe_pixel_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         req_type,
  input  logic [ppe_pkg::COLOR_W-1:0]  palette_index,
  input  logic [ppe_pkg::COLOR_W-1:0]  red,
  input  logic [ppe_pkg::COLOR_W-1:0]  green,
  input  logic [ppe_pkg::COLOR_W-1:0]  blue,
  input  logic [ppe_pkg::COLOR_W-1:0]  packed_byte,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [ppe_pkg::PIXEL_W-1:0]  pixel,
  input  logic                         last_pixel,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppe_pkg::CFG_AW-1:0]   paddr,
  input  logic [ppe_pkg::CFG_DW-1:0]   pwdata,
  input  logic [ppe_pkg::CFG_DW-1:0]   prdata,
  input  logic                         pready,
  output int                           errors,
  output int                           outstanding
);
  import ppe_pkg::*;

  logic [ENTRY_W-1:0] palette_copy [PALETTE_DEPTH];
  depth_mode_t        depth_mode;
  out_word_t          pixel_queue[$];

  initial begin
    errors = 0;
    outstanding = 0;
    depth_mode = MODE_8BPP;
  end

  task automatic flag_error(input string what);
    errors++;
    if (errors <= 10)
      $display("%0t mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    out_word_t          want;
    logic [ENTRY_W-1:0] entry;
    logic [7:0]         idx;
    int                 count;
    int                 bits;
    if (rst) begin
      pixel_queue.delete();
      depth_mode = MODE_8BPP;
    end else begin
      if (out_valid && !out_stall) begin
        if (pixel_queue.size() == 0) begin
          flag_error($sformatf("unexpected word pixel=%h last=%b", pixel, last_pixel));
        end else begin
          want = pixel_queue.pop_front();
          if (pixel !== want.pixel || last_pixel !== want.last)
            flag_error($sformatf("pixel exp %h got %h, last exp %b got %b",
                                 want.pixel, pixel, want.last, last_pixel));
        end
      end

      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == REG_DEPTH_MODE_ADDR)
            depth_mode = depth_mode_t'(pwdata[1:0]);
        end else if (paddr == REG_DEPTH_MODE_ADDR) begin
          if (prdata !== CFG_DW'(depth_mode))
            flag_error($sformatf("depth mode read exp %h got %h",
                                 CFG_DW'(depth_mode), prdata));
        end
      end

      if (in_valid && !in_stall) begin
        if (req_type == REQ_PALETTE_WRITE) begin
          palette_copy[palette_index] = {red[7:3], green[7:3], blue[7:3]};
        end else begin
          case (depth_mode)
            MODE_1BPP: bits = 1;
            MODE_2BPP: bits = 2;
            MODE_4BPP: bits = 4;
            default:   bits = 8;
          endcase
          count = 8 / bits;
          for (int k = 0; k < count; k++) begin
            // 1-bit mode is LSB first, wider modes take the top field first
            if (bits == 1)
              idx = 8'((packed_byte >> k) & 8'h1);
            else
              idx = 8'((packed_byte >> (8 - bits * (k + 1))) & ((1 << bits) - 1));
            entry = palette_copy[idx];
            want.pixel = {entry[14:10], entry[9:5], 1'b0, entry[4:0]};
            want.last  = (k == count - 1);
            pixel_queue.push_back(want);
          end
        end
      end
    end
    outstanding <= pixel_queue.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the palette pixel expander testbench: clock, reset, bursty input
// stimulus, output stall patterns and config writes; verdict from the checker.
// Depends on ppe_pkg, palette_pixel_expander and ppe_pixel_checker.
module testbench;
  import ppe_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               req_type = REQ_PALETTE_WRITE;
  logic [COLOR_W-1:0] palette_index = '0;
  logic [COLOR_W-1:0] red = '0;
  logic [COLOR_W-1:0] green = '0;
  logic [COLOR_W-1:0] blue = '0;
  logic [COLOR_W-1:0] packed_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PIXEL_W-1:0] pixel;
  logic               last_pixel;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [CFG_AW-1:0]  paddr = '0;
  logic [CFG_DW-1:0]  pwdata = '0;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;

  int                 errors;
  int                 pending;

  logic               palette_loaded [PALETTE_DEPTH];
  depth_mode_t        cur_mode = MODE_8BPP;
  int                 burst_left = 0;

  logic [5:0]         stall_window = '0;
  int                 stall_style = 0;
  int                 stall_hold = 0;

  always #5 clk = ~clk;

  palette_pixel_expander uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .palette_index(palette_index),
    .red(red), .green(green), .blue(blue), .packed_byte(packed_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel(pixel), .last_pixel(last_pixel),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ppe_pixel_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .palette_index(palette_index),
    .red(red), .green(green), .blue(blue), .packed_byte(packed_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel(pixel), .last_pixel(last_pixel),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .errors(errors), .outstanding(pending)
  );

  // receiver stall pattern, new style each time the 6-bit window counter wraps
  always @(posedge clk) begin
    stall_window <= stall_window + 6'd1;
    if (stall_window == '0)
      stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= (stall_window % 3 == 0);
      default: begin
        if (stall_hold > 0) begin
          out_stall <= 1'b1;
          stall_hold <= stall_hold - 1;
        end else if ($urandom_range(0, 7) == 0) begin
          out_stall <= 1'b1;
          stall_hold <= $urandom_range(3, 20);
        end else begin
          out_stall <= 1'b0;
        end
      end
    endcase
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_word(input logic rt, input logic [7:0] pi, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b,
                           input logic [7:0] pb);
    int gap;
    in_valid      <= 1'b1;
    req_type      <= rt;
    palette_index <= pi;
    red           <= r;
    green         <= g;
    blue          <= b;
    packed_byte   <= pb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (rt == REQ_PALETTE_WRITE)
      palette_loaded[pi] = 1'b1;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic load_entry(input logic [7:0] pi, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
    send_word(REQ_PALETTE_WRITE, pi, r, g, b, 8'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] pb);
    send_word(REQ_PIXEL_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), pb);
  endtask

  // wait until every expected pixel is out, then let a trailing write finish
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= REG_DEPTH_MODE_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input depth_mode_t m);
    drain();
    apb_access(1'b1, ($urandom() & ~32'h3) | CFG_DW'(m));
    apb_access(1'b0, $urandom());
    cur_mode = m;
  endtask

  // first palette index of byte b, in mode m, not yet written, or -1
  function automatic int first_missing(input depth_mode_t m, input logic [7:0] b);
    int         bits;
    logic [7:0] idx;
    case (m)
      MODE_1BPP: bits = 1;
      MODE_2BPP: bits = 2;
      MODE_4BPP: bits = 4;
      default:   bits = 8;
    endcase
    for (int s = 0; s < 8; s += bits) begin
      idx = 8'((b >> s) & ((1 << bits) - 1));
      if (!palette_loaded[idx])
        return int'(idx);
    end
    return -1;
  endfunction

  task automatic random_items(input int n);
    logic [7:0] b;
    int         miss;
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) begin
        load_entry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        miss = 0;
        for (int t = 0; t < 8 && miss >= 0; t++) begin
          b = 8'($urandom);
          miss = first_missing(cur_mode, b);
        end
        if (miss < 0)
          send_byte(b);
        else
          load_entry(8'(miss), 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    depth_mode_t plan [7];
    for (int i = 0; i < PALETTE_DEPTH; i++)
      palette_loaded[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset value read back, then 8-bit mode without any write
    apb_access(1'b0, '0);
    load_entry(8'h00, 8'h00, 8'h00, 8'h00);
    load_entry(8'h01, 8'hFF, 8'hFF, 8'hFF);
    load_entry(8'hFF, 8'hF8, 8'h07, 8'hAA);
    load_entry(8'h02, 8'h07, 8'hF8, 8'h55);
    load_entry(8'h03, 8'h80, 8'h40, 8'h08);
    load_entry(8'h0F, 8'h3C, 8'hC3, 8'hF0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);

    set_mode(MODE_1BPP);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);

    set_mode(MODE_2BPP);
    send_byte(8'h1B);
    send_byte(8'hE4);

    set_mode(MODE_4BPP);
    send_byte(8'h03);
    send_byte(8'h30);
    send_byte(8'hF0);
    send_byte(8'hFF);

    plan = '{MODE_1BPP, MODE_8BPP, MODE_2BPP, MODE_4BPP, MODE_8BPP, MODE_1BPP,
             depth_mode_t'($urandom_range(0, 3))};
    foreach (plan[p]) begin
      set_mode(plan[p]);
      random_items(45);
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
